/* design/stef_pkg.sv */
package stef_pkg;

  // default vertex count and fixed vertex field width
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int VERT_W           = 10;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RANGE,
    ST_WALK_RD,
    ST_WALK,
    ST_COMP,
    ST_LINK,
    ST_OUT
  } stef_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic walk_start;
    logic walk_step;
    logic comp_step;
    logic save_ra;
    logic link;
    logic out_load;
  } stef_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_root;
    logic comp_done;
    logic in_range;
    logic clr_last;
    logic sel_b;
    logic out_free;
  } stef_status_t;

endpackage

/* design/stef_ctrl.sv */
module stef_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_new_graph,
  input  stef_pkg::stef_status_t sts,
  output stef_pkg::stef_cmd_t  cmd,
  output logic                 in_stall
);
  import stef_pkg::*;

  stef_state_t state_r;
  stef_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = in_new_graph ? ST_CLEAR : ST_RANGE;
      end
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        state_nxt = sts.in_range ? ST_WALK_RD : ST_OUT;
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.is_root) state_nxt = ST_COMP;
      end
      ST_COMP: begin
        if (sts.comp_done) state_nxt = sts.sel_b ? ST_LINK : ST_WALK_RD;
      end
      ST_LINK: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RANGE: begin
      end
      ST_WALK_RD: begin
        cmd.walk_start = 1'b1;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
      end
      ST_COMP: begin
        cmd.comp_step = 1'b1;
        cmd.save_ra   = sts.comp_done & ~sts.sel_b;
      end
      ST_LINK: begin
        cmd.link = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/stef_dpath.sv */
module stef_dpath #(
  parameter int MAX_VERTICES = stef_pkg::DEF_MAX_VERTICES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [stef_pkg::VERT_W-1:0] in_vertex_a,
  input  logic [stef_pkg::VERT_W-1:0] in_vertex_b,
  input  logic                        out_stall,
  input  stef_pkg::stef_cmd_t         cmd,
  output stef_pkg::stef_status_t      sts,
  output logic                        out_valid,
  output logic                        out_joins_trees,
  output logic [stef_pkg::VERT_W-1:0] out_edge_a,
  output logic [stef_pkg::VERT_W-1:0] out_edge_b
);
  import stef_pkg::*;

  localparam int          AW   = $clog2(MAX_VERTICES);
  localparam logic [31:0] MaxV = 32'(MAX_VERTICES);

  // parent table
  logic [AW-1:0] mem [MAX_VERTICES];
  logic [AW-1:0] rdata_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wr_data;

  logic [VERT_W-1:0] a_r, a_nxt;
  logic [VERT_W-1:0] b_r, b_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [AW-1:0]     root_r, root_nxt;
  logic [AW-1:0]     ra_r, ra_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              sel_b_r, sel_b_nxt;
  logic              joined_r, joined_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_joins_r;
  logic [VERT_W-1:0] out_a_r;
  logic [VERT_W-1:0] out_b_r;

  logic [AW-1:0] start_v;
  logic          is_root;
  logic          comp_done;
  logic          clr_last;

  assign start_v   = sel_b_r ? AW'(b_r) : AW'(a_r);
  assign is_root   = (rdata_r == cur_r);
  assign comp_done = (cur_r == root_r);
  assign clr_last  = (32'(cnt_r) == MaxV - 32'd1);

  assign sts.is_root   = is_root;
  assign sts.comp_done = comp_done;
  assign sts.in_range  = (32'(a_r) < MaxV) && (32'(b_r) < MaxV);
  assign sts.clr_last  = clr_last;
  assign sts.sel_b     = sel_b_r;
  assign sts.out_free  = ~out_valid_r | ~out_stall;

  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    cur_nxt    = cur_r;
    root_nxt   = root_r;
    ra_nxt     = ra_r;
    cnt_nxt    = cnt_r;
    sel_b_nxt  = sel_b_r;
    joined_nxt = joined_r;
    rd_addr    = cur_r;
    wr_en      = 1'b0;
    wr_addr    = cnt_r;
    wr_data    = cnt_r;

    if (cmd.load) begin
      a_nxt      = in_vertex_a;
      b_nxt      = in_vertex_b;
      sel_b_nxt  = 1'b0;
      joined_nxt = 1'b0;
      cnt_nxt    = '0;
    end
    // identity sweep, one entry a cycle
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      cnt_nxt = clr_last ? '0 : cnt_r + AW'(1);
    end
    if (cmd.walk_start) begin
      cur_nxt = start_v;
      rd_addr = start_v;
    end
    // follow parent links; on the root, restart at the endpoint for compression
    if (cmd.walk_step) begin
      if (is_root) begin
        root_nxt = cur_r;
        cur_nxt  = start_v;
        rd_addr  = start_v;
      end else begin
        cur_nxt = rdata_r;
        rd_addr = rdata_r;
      end
    end
    // point each node on the path at the root while fetching the next one
    if (cmd.comp_step && !comp_done) begin
      wr_en   = 1'b1;
      wr_addr = cur_r;
      wr_data = root_r;
      cur_nxt = rdata_r;
      rd_addr = rdata_r;
    end
    if (cmd.save_ra) begin
      ra_nxt    = root_r;
      sel_b_nxt = 1'b1;
    end
    // first root goes under second root
    if (cmd.link && (ra_r != root_r)) begin
      wr_en      = 1'b1;
      wr_addr    = ra_r;
      wr_data    = root_r;
      joined_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sel_b_r     <= 1'b0;
      joined_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sel_b_r     <= sel_b_nxt;
      joined_r    <= joined_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    cur_r  <= cur_nxt;
    root_r <= root_nxt;
    ra_r   <= ra_nxt;
    if (cmd.out_load) begin
      out_joins_r <= joined_r;
      out_a_r     <= a_r;
      out_b_r     <= b_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_joins_trees = out_joins_r;
  assign out_edge_a      = out_a_r;
  assign out_edge_b      = out_b_r;

endmodule

/* design/spanning_tree_edge_filter_unit.sv */
// spanning tree edge filter: takes weight-sorted edges, one item per edge, and tells for
// each whether it joins two different sets of a union-find parent table (a tree edge);
// the first root is then linked under the second and both endpoints are echoed. both
// finds compress their path fully. an edge with an endpoint at or above MAX_VERTICES
// gives joins_trees = 0 and leaves the table alone. an item's time grows with the
// number of links from each endpoint up to its root, set by the one-read, one-write
// parent memory that every link step goes through. an out-of-range edge skips the
// finds and goes straight to the output. new_graph adds an identity sweep of the
// whole table before the edge. after reset the same sweep runs once with in_stall
// high. the next item is taken while a result still waits in the output register.
module spanning_tree_edge_filter_unit #(
  parameter int MAX_VERTICES = stef_pkg::DEF_MAX_VERTICES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [stef_pkg::VERT_W-1:0] in_vertex_a,
  input  logic [stef_pkg::VERT_W-1:0] in_vertex_b,
  input  logic                        in_new_graph,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_joins_trees,
  output logic [stef_pkg::VERT_W-1:0] out_edge_a,
  output logic [stef_pkg::VERT_W-1:0] out_edge_b
);
  import stef_pkg::*;

  // command and status between sequencer and datapath
  stef_cmd_t    cmd;
  stef_status_t sts;

  // sequencer: clearing sweep, two finds with compression, link, result hand-off
  stef_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_new_graph (in_new_graph),
    .sts          (sts),
    .cmd          (cmd),
    .in_stall     (in_stall)
  );

  // datapath: parent memory, walk registers and output register
  stef_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_joins_trees (out_joins_trees),
    .out_edge_a      (out_edge_a),
    .out_edge_b      (out_edge_b)
  );

endmodule

/* design/stef_checker.sv */
module stef_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [stef_pkg::VERT_W-1:0] in_vertex_a,
  input logic [stef_pkg::VERT_W-1:0] in_vertex_b,
  input logic                        in_new_graph,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_joins_trees,
  input logic [stef_pkg::VERT_W-1:0] out_edge_a,
  input logic [stef_pkg::VERT_W-1:0] out_edge_b
);
  import stef_pkg::*;

  // items taken but not yet delivered
  logic [1:0] pending_r;
  logic [1:0] pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  always_comb begin
    pending_nxt = pending_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // clearing sweep holds off input right after reset
  a_sweep_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during reset sweep");

  // no result without an item behind it
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result without accepted item");

  // at most one item in work plus one waiting result
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("too many items in flight");

  // a self loop never joins two sets
  a_self_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_joins_trees |-> out_edge_a != out_edge_b)
    else $error("self loop reported as tree edge");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_joins_trees)
      && $stable(out_edge_a) && $stable(out_edge_b))
    else $error("stalled result changed");

endmodule

bind spanning_tree_edge_filter_unit stef_checker u_stef_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_vertex_a     (in_vertex_a),
  .in_vertex_b     (in_vertex_b),
  .in_new_graph    (in_new_graph),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_joins_trees (out_joins_trees),
  .out_edge_a      (out_edge_a),
  .out_edge_b      (out_edge_b)
);
